// ===== rtl/svp_pkg.sv =====
`timescale 1ns / 1ps

package svp_pkg;

	localparam int VOICES       = 16;
	localparam int SAMPLE_DEPTH = 65536;
	localparam int AW           = $clog2(SAMPLE_DEPTH);
	localparam int VI_W         = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CNT_W        = $clog2(VOICES + 1);

	// position math: signed Q24.16 with headroom
	localparam int P_W     = 42;
	localparam int DVD_W   = 48;
	localparam int DSR_W   = 35;
	localparam int SUM_W   = 48 + VI_W + 1;

	typedef logic signed [P_W-1:0] pos_t;

	// operation codes
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_NOTE_ON  = 3'd1;
	localparam logic [2:0] OP_NOTE_OFF = 3'd2;
	localparam logic [2:0] OP_BEND     = 3'd3;
	localparam logic [2:0] OP_WRITE    = 3'd4;
	localparam logic [2:0] OP_QUERY    = 3'd5;

	// register indexes
	localparam logic [2:0] REG_START  = 3'd0;
	localparam logic [2:0] REG_END    = 3'd1;
	localparam logic [2:0] REG_LOOP   = 3'd2;
	localparam logic [2:0] REG_MODE   = 3'd3;
	localparam logic [2:0] REG_REV    = 3'd4;
	localparam logic [2:0] REG_ROOT   = 3'd5;
	localparam logic [2:0] REG_SRATE  = 3'd6;
	localparam logic [2:0] REG_ORATE  = 3'd7;

	localparam logic [1:0] MODE_ONESHOT = 2'd0;
	localparam logic [1:0] MODE_ALT     = 2'd2;

	localparam logic [63:0] ROM_STEP_Q30 = 64'd1077625190;

	typedef logic [191:0][30:0] rom_t;

	// 2^(k/192) in Q30, built by repeated multiplication
	function automatic rom_t build_rom();
		rom_t r;
		logic [63:0] e;
		e = 64'd1 << 30;
		for (int k = 0; k < 192; k++) begin
			r[k] = e[30:0];
			e = (e * ROM_STEP_Q30 + (64'd1 << 29)) >> 30;
		end
		return r;
	endfunction

	localparam rom_t PITCH_ROM = build_rom();

	// u / 192 for u < 6144, via (u >> 6) / 3 by reciprocal
	function automatic logic [4:0] div192(input logic [12:0] u);
		logic [16:0] t;
		t = 17'(u[12:6]) * 17'd683;
		return t[15:11];
	endfunction

endpackage

// ===== rtl/svp_ram.sv =====
`timescale 1ns / 1ps

module svp_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/sample_voice_pool_player_top.sv =====
`timescale 1ns / 1ps
// Note-off, bend, query and sample write go from the operation state to the result.
// Note-on computes its step on the shared divider (48 bits); when no voice is idle,
// it first scans the voices for the oldest one to steal.
// Tick visits each voice in turn and skips idle ones; a voice that wraps first runs
// the shared divider (one bit a cycle); one item at a time.
// Reset (arst_n low, asynchronous) stops all voices and loads register defaults;
// sample memory is not cleared.
module sample_voice_pool_player_top (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// key[6:0], voice_tag[23:7], strength[39:24], bend_amount[55:40],
	// bend_span[62:56], store_address[78:63], store_value[90:79], zero pad
	input  logic [95:0] s_tdata,
	input  logic [2:0]  s_tuser,    // operation[2:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // mix[25:0], active_voices[30:26], note_active[31]
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import svp_pkg::*;

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_OP     = 4'd1;
	localparam logic [3:0] ST_TLOAD  = 4'd2;
	localparam logic [3:0] ST_TDIV   = 4'd3;
	localparam logic [3:0] ST_TRD0   = 4'd4;
	localparam logic [3:0] ST_TRD1   = 4'd5;
	localparam logic [3:0] ST_TMAC   = 4'd6;
	localparam logic [3:0] ST_TACC   = 4'd7;
	localparam logic [3:0] ST_TSUM   = 4'd8;
	localparam logic [3:0] ST_TFIN   = 4'd9;
	localparam logic [3:0] ST_NSCAN  = 4'd10;
	localparam logic [3:0] ST_NMUL   = 4'd11;
	localparam logic [3:0] ST_NSTART = 4'd12;
	localparam logic [3:0] ST_NDIV   = 4'd13;
	localparam logic [3:0] ST_DONE   = 4'd14;

	// wrap kinds found when a voice is loaded
	localparam logic [2:0] WK_NONE = 3'd0;
	localparam logic [2:0] WK_AFWD = 3'd1;
	localparam logic [2:0] WK_ABWD = 3'd2;
	localparam logic [2:0] WK_FWD  = 3'd3;
	localparam logic [2:0] WK_BWD  = 3'd4;

	localparam logic [VI_W-1:0] LAST_VOICE = VI_W'(VOICES - 1);

	// ---------------- configuration registers ----------------
	logic [15:0] cfg_start_q;
	logic [16:0] cfg_end_q;
	logic [16:0] cfg_loop_q;
	logic [1:0]  cfg_mode_q;
	logic        cfg_rev_q;
	logic [10:0] cfg_root_q;
	logic [15:0] cfg_srate_q;
	logic [17:0] cfg_orate_q;

	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_start_q <= '0;
			cfg_end_q   <= '0;
			cfg_loop_q  <= '0;
			cfg_mode_q  <= '0;
			cfg_rev_q   <= 1'b0;
			cfg_root_q  <= 11'd960;
			cfg_srate_q <= '0;
			cfg_orate_q <= 18'd48000;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_START: cfg_start_q <= pwdata[15:0];
				REG_END:   cfg_end_q   <= pwdata[16:0];
				REG_LOOP:  cfg_loop_q  <= pwdata[16:0];
				REG_MODE:  cfg_mode_q  <= pwdata[1:0];
				REG_REV:   cfg_rev_q   <= pwdata[0];
				REG_ROOT:  cfg_root_q  <= pwdata[10:0];
				REG_SRATE: cfg_srate_q <= pwdata[15:0];
				REG_ORATE: begin
					// zero rate is ignored
					if (pwdata[17:0] != '0) begin
						cfg_orate_q <= pwdata[17:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_START: prdata = 32'(cfg_start_q);
			REG_END:   prdata = 32'(cfg_end_q);
			REG_LOOP:  prdata = 32'(cfg_loop_q);
			REG_MODE:  prdata = 32'(cfg_mode_q);
			REG_REV:   prdata = 32'(cfg_rev_q);
			REG_ROOT:  prdata = 32'(cfg_root_q);
			REG_SRATE: prdata = 32'(cfg_srate_q);
			REG_ORATE: prdata = 32'(cfg_orate_q);
		endcase
	end

	// ---------------- state ----------------
	logic [3:0]  state_q;
	logic [2:0]  op_q;
	logic [6:0]  key_q;
	logic signed [16:0] tag_q;
	logic [15:0] strength_q;
	logic signed [15:0] bend_q;
	logic [6:0]  bspan_q;

	logic        present_q;
	logic [31:0] age_ctr_q;
	logic [17:0] bend_ratio_q;

	// voice table: flop arrays, read at the sequencer's voice index
	logic [VOICES-1:0] on_q;
	logic [VOICES-1:0] vback_q;
	logic [6:0]        vkey_q   [VOICES];
	logic signed [16:0] vid_q   [VOICES];
	logic [15:0]       vgain_q  [VOICES];
	logic [39:0]       vpos_q   [VOICES];
	logic [31:0]       vstep_q  [VOICES];
	logic [31:0]       vage_q   [VOICES];

	logic [VI_W-1:0] vi_q;
	logic [VI_W-1:0] sel_q;
	logic [31:0]     best_age_q;

	// note-on pitch path
	logic [4:0]  sh_q;
	logic [7:0]  rom_idx_q;
	logic [46:0] num_q;

	// tick datapath
	pos_t        p_q;
	logic        back_q;
	logic [2:0]  kind_q;
	logic [AW-1:0] nxt_q;
	logic [33:0] adv_q;
	logic signed [11:0] s0_q;
	logic signed [30:0] interp_q;
	logic signed [47:0] prod_q;
	logic signed [SUM_W-1:0] sum_q;

	// result staging
	logic signed [25:0] mix_q;
	logic        found_q;
	logic        m_valid_q;
	logic [31:0] m_data_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	logic s_acc;
	assign s_acc = s_tvalid & s_tready;

	// ---------------- sample memory ----------------
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [11:0]   ram_rdata;

	assign ram_we = s_acc && (s_tuser == OP_WRITE);

	svp_ram #(
		.WIDTH(12),
		.DEPTH(SAMPLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (s_tdata[63 +: AW]),
		.wdata (s_tdata[90:79]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------- shared divider ----------------
	// restoring, one quotient bit per cycle, DVD_W quotient bits
	logic               dv_start;
	logic [DVD_W-1:0]   dv_in_dvd;
	logic [DSR_W-1:0]   dv_in_dsr;
	logic               dv_busy_q;
	logic [5:0]         dv_cnt_q;
	logic [DVD_W-1:0]   dv_dvd_q;
	logic [DVD_W-1:0]   dv_quo_q;
	logic [DSR_W-1:0]   dv_dsr_q;
	logic [DSR_W:0]     dv_rem_q;
	logic [DSR_W:0]     dv_trial;
	logic               dv_fit;

	assign dv_trial = {dv_rem_q[DSR_W-1:0], dv_dvd_q[DVD_W-1]};
	assign dv_fit   = (dv_trial >= {1'b0, dv_dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else if (dv_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q  <= 6'(DVD_W);
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q - 6'd1;
			if (dv_cnt_q == 6'd1) begin
				dv_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dv_start) begin
			dv_dvd_q <= dv_in_dvd;
			dv_dsr_q <= dv_in_dsr;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
		end else if (dv_busy_q) begin
			dv_dvd_q <= {dv_dvd_q[DVD_W-2:0], 1'b0};
			dv_quo_q <= {dv_quo_q[DVD_W-2:0], dv_fit};
			dv_rem_q <= dv_fit ? (dv_trial - {1'b0, dv_dsr_q}) : dv_trial;
		end
	end

	// ---------------- loop geometry in Q16 ----------------
	pos_t c_s, c_e, c_h, c_l, c_span, c_span2, c_el;
	logic c_alt;

	always_comb begin
		c_s     = pos_t'({cfg_start_q, 16'h0});
		c_e     = pos_t'({cfg_end_q, 16'h0});
		c_l     = pos_t'({cfg_loop_q, 16'h0});
		c_h     = c_e - pos_t'(65536);
		c_span  = c_h - c_l;
		c_span2 = c_span <<< 1;
		c_el    = c_e - c_l;
		c_alt   = (cfg_mode_q == MODE_ALT) && (c_l < c_h);
	end

	// ---------------- voice load: decide wrap ----------------
	pos_t        t_pv;
	logic        t_bk;
	logic [2:0]  t_kind;
	logic        t_end;
	pos_t        t_diff;
	pos_t        t_dsr;
	logic        t_loop_dead;

	always_comb begin
		t_pv   = pos_t'(signed'(vpos_q[vi_q]));
		t_bk   = vback_q[vi_q];
		t_kind = WK_NONE;
		t_end  = 1'b0;
		t_diff = '0;
		t_dsr  = c_el;
		t_loop_dead = (cfg_mode_q == MODE_ONESHOT) || (c_l >= c_e);
		priority if (c_alt) begin
			t_dsr = c_span2;
			if (!t_bk && (t_pv > c_h)) begin
				t_kind = WK_AFWD;
				t_diff = t_pv - c_h;
			end else if (t_bk && (t_pv < c_l)) begin
				t_kind = WK_ABWD;
				t_diff = c_l - t_pv;
			end
		end else if (!t_bk && (t_pv >= c_e)) begin
			t_end  = t_loop_dead;
			t_kind = WK_FWD;
			t_diff = t_pv - c_e;
		end else if (t_bk && (t_pv < ((cfg_mode_q == MODE_ONESHOT) ? c_s : c_l))) begin
			t_end  = t_loop_dead;
			t_kind = WK_BWD;
			t_diff = c_l - t_pv;
		end else begin
			t_kind = WK_NONE;
		end
	end

	// ---------------- wrap fix-up from remainder ----------------
	pos_t f_ph;
	pos_t f_p;
	logic f_back;

	always_comb begin
		f_ph   = pos_t'(dv_rem_q);
		f_p    = p_q;
		f_back = back_q;
		unique case (kind_q)
			WK_AFWD: begin
				if (f_ph <= c_span) begin
					f_p    = c_h - f_ph;
					f_back = 1'b1;
				end else begin
					f_p = c_l + (f_ph - c_span);
				end
			end
			WK_ABWD: begin
				if (f_ph <= c_span) begin
					f_p    = c_l + f_ph;
					f_back = 1'b0;
				end else begin
					f_p = c_h - (f_ph - c_span);
				end
			end
			WK_FWD:  f_p = c_l + f_ph;
			WK_BWD:  f_p = (f_ph == '0) ? c_l : (c_e - f_ph);
			default: f_p = p_q;
		endcase
	end

	// ---------------- read addresses ----------------
	logic [P_W-17:0] r_idx;
	logic [P_W-17:0] r_lim;
	logic [AW-1:0]   r_nxt;

	always_comb begin
		r_idx = p_q[P_W-1:16];
		r_lim = (P_W-16)'(cfg_end_q - 17'd1);
		if ((cfg_end_q != '0) && (r_idx >= r_lim)) begin
			r_nxt = r_lim[AW-1:0];
		end else begin
			r_nxt = r_idx[AW-1:0] + AW'(1);
		end
		ram_raddr = (state_q == ST_TRD1) ? nxt_q : r_idx[AW-1:0];
	end

	// ---------------- interpolation ----------------
	logic signed [11:0] i_s1;
	logic signed [12:0] i_diff;
	logic signed [29:0] i_slope;

	always_comb begin
		i_s1    = signed'(ram_rdata);
		i_diff  = 13'(i_s1) - 13'(s0_q);
		i_slope = i_diff * signed'({1'b0, p_q[15:0]});
	end

	// ---------------- per-op combinational helpers ----------------
	logic [VOICES-1:0] idle_v, tag_m, key_m, off_m, qry_m;
	logic [VI_W-1:0]   first_idle;
	logic [CNT_W-1:0]  on_count;
	logic              refused;

	always_comb begin
		idle_v     = ~on_q;
		first_idle = '0;
		on_count   = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (idle_v[i]) begin
				first_idle = VI_W'(i);
			end
		end
		for (int i = 0; i < VOICES; i++) begin
			tag_m[i] = on_q[i] && (vid_q[i] == tag_q);
			key_m[i] = on_q[i] && (vkey_q[i] == key_q);
			qry_m[i] = key_m[i] && (tag_q[16] || (vid_q[i] == tag_q));
			on_count = on_count + CNT_W'(on_q[i]);
		end
		// first matching tag only
		off_m = tag_q[16] ? key_m : (tag_m & (~tag_m + VOICES'(1)));
		refused = !present_q || (cfg_srate_q == '0) ||
			(cfg_end_q <= {1'b0, cfg_start_q}) || (strength_q == '0);
	end

	// note-on pitch split: key*16 + 2304 - root = 192*oct + k
	logic [12:0] n_u;
	logic [4:0]  n_q;
	logic [12:0] n_r;

	always_comb begin
		n_u = 13'({key_q, 4'h0}) + 13'd2304 - 13'(cfg_root_q);
		n_q = div192(n_u);
		n_r = n_u - 13'(n_q) * 13'd192;
	end

	// bend: x = floor(amount*span/2048), ratio = 2^(x/192) in Q16
	logic [3:0]         b_span;
	logic signed [20:0] b_prod;
	logic signed [9:0]  b_x;
	logic [12:0]        b_u;
	logic [4:0]         b_q;
	logic [12:0]        b_r;
	logic [30:0]        b_rom;

	always_comb begin
		if (bspan_q == '0) begin
			b_span = 4'd1;
		end else if (bspan_q > 7'd12) begin
			b_span = 4'd12;
		end else begin
			b_span = bspan_q[3:0];
		end
		b_prod = bend_q * signed'({1'b0, b_span});
		b_x    = 10'(b_prod >>> 11);
		b_u    = 13'(11'(b_x) + 11'sd192);
		b_q    = div192(b_u);
		b_r    = b_u - 13'(b_q) * 13'd192;
		b_rom  = PITCH_ROM[b_r[7:0]];
	end

	// mix: floor(sum / 2^23) saturated to +-2^24
	logic signed [SUM_W-24:0] x_sh;
	logic signed [25:0]       x_mix;

	always_comb begin
		x_sh = (SUM_W-23)'(sum_q >>> 23);
		if (x_sh > (SUM_W-23)'(1 << 24)) begin
			x_mix = 26'sd16777216;
		end else if (x_sh < -(SUM_W-23)'(1 << 24)) begin
			x_mix = -26'sd16777216;
		end else begin
			x_mix = 26'(x_sh);
		end
	end

	// divider launch
	always_comb begin
		dv_start  = 1'b0;
		dv_in_dvd = DVD_W'(num_q >> sh_q);
		dv_in_dsr = DSR_W'(cfg_orate_q);
		if (state_q == ST_NSTART) begin
			dv_start = 1'b1;
		end else if ((state_q == ST_TLOAD) && on_q[vi_q] && !t_end && (t_kind != WK_NONE)) begin
			dv_start  = 1'b1;
			dv_in_dvd = DVD_W'(unsigned'(t_diff));
			dv_in_dsr = DSR_W'(unsigned'(t_dsr));
		end
	end

	logic [31:0] n_step;
	assign n_step = (dv_quo_q[DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : dv_quo_q[31:0];

	// ---------------- sequencer: control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			present_q    <= 1'b0;
			on_q         <= '0;
			age_ctr_q    <= 32'd1;
			bend_ratio_q <= 18'd65536;
			vi_q         <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			// result register: load when done, drop once taken
			if ((state_q == ST_DONE) && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_OP;
						if (s_tuser == OP_WRITE) begin
							present_q <= 1'b1;
							on_q      <= '0;
							age_ctr_q <= 32'd1;
						end
					end
				end
				ST_OP: begin
					state_q <= ST_DONE;
					unique case (op_q)
						OP_TICK: begin
							vi_q    <= '0;
							state_q <= ST_TLOAD;
						end
						OP_NOTE_ON: begin
							if (!refused) begin
								if (|idle_v) begin
									state_q <= ST_NMUL;
								end else if (VOICES > 1) begin
									vi_q    <= VI_W'(1);
									state_q <= ST_NSCAN;
								end else begin
									state_q <= ST_NMUL;
								end
							end
						end
						OP_NOTE_OFF: on_q <= on_q & ~off_m;
						OP_BEND:     bend_ratio_q <= 18'(b_rom >> (5'd15 - b_q));
						default:     state_q <= ST_DONE;
					endcase
				end
				ST_TLOAD: begin
					if (!on_q[vi_q] || t_end) begin
						if (t_end) begin
							on_q[vi_q] <= 1'b0;
						end
						if (vi_q == LAST_VOICE) begin
							state_q <= ST_TFIN;
						end else begin
							vi_q <= vi_q + VI_W'(1);
						end
					end else if (t_kind == WK_NONE) begin
						state_q <= ST_TRD0;
					end else begin
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (!dv_busy_q) begin
						state_q <= ST_TRD0;
					end
				end
				ST_TRD0: state_q <= ST_TRD1;
				ST_TRD1: state_q <= ST_TMAC;
				ST_TMAC: state_q <= ST_TACC;
				ST_TACC: state_q <= ST_TSUM;
				ST_TSUM: begin
					if (vi_q == LAST_VOICE) begin
						state_q <= ST_TFIN;
					end else begin
						vi_q    <= vi_q + VI_W'(1);
						state_q <= ST_TLOAD;
					end
				end
				ST_TFIN: state_q <= ST_DONE;
				ST_NSCAN: begin
					if (vi_q == LAST_VOICE) begin
						state_q <= ST_NMUL;
					end else begin
						vi_q <= vi_q + VI_W'(1);
					end
				end
				ST_NMUL:   state_q <= ST_NSTART;
				ST_NSTART: state_q <= ST_NDIV;
				ST_NDIV: begin
					if (!dv_busy_q) begin
						on_q[sel_q] <= 1'b1;
						age_ctr_q   <= age_ctr_q + 32'd1;
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- sequencer: datapath ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					op_q       <= s_tuser;
					key_q      <= s_tdata[6:0];
					tag_q      <= signed'(s_tdata[23:7]);
					strength_q <= s_tdata[39:24];
					bend_q     <= signed'(s_tdata[55:40]);
					bspan_q    <= s_tdata[62:56];
				end
			end
			ST_OP: begin
				mix_q      <= '0;
				found_q    <= (op_q == OP_QUERY) && (|qry_m);
				sum_q      <= '0;
				sh_q       <= 5'd26 - n_q;
				rom_idx_q  <= n_r[7:0];
				sel_q      <= (|idle_v) ? first_idle : '0;
				best_age_q <= vage_q[0];
			end
			ST_TLOAD: begin
				p_q    <= t_pv;
				back_q <= t_bk;
				kind_q <= t_kind;
			end
			ST_TDIV: begin
				if (!dv_busy_q) begin
					p_q    <= f_p;
					back_q <= f_back;
				end
			end
			ST_TRD0: begin
				nxt_q <= r_nxt;
				adv_q <= 34'((50'(vstep_q[vi_q]) * 50'(bend_ratio_q)) >> 16);
			end
			ST_TRD1: s0_q <= signed'(ram_rdata);
			ST_TMAC: begin
				interp_q       <= 31'(signed'({s0_q, 16'h0})) + 31'(i_slope);
				vpos_q[vi_q]   <= 40'(back_q ? (p_q - pos_t'(adv_q)) : (p_q + pos_t'(adv_q)));
				vback_q[vi_q]  <= back_q;
			end
			ST_TACC: prod_q <= interp_q * signed'({1'b0, vgain_q[vi_q]});
			ST_TSUM: sum_q <= sum_q + SUM_W'(prod_q);
			ST_TFIN: mix_q <= x_mix;
			ST_NSCAN: begin
				if (vage_q[vi_q] < best_age_q) begin
					best_age_q <= vage_q[vi_q];
					sel_q      <= vi_q;
				end
			end
			ST_NMUL: num_q <= 47'(cfg_srate_q) * 47'(PITCH_ROM[rom_idx_q]);
			ST_NDIV: begin
				if (!dv_busy_q) begin
					vkey_q[sel_q]  <= key_q;
					vid_q[sel_q]   <= tag_q;
					vgain_q[sel_q] <= strength_q;
					vback_q[sel_q] <= cfg_rev_q;
					vpos_q[sel_q]  <= cfg_rev_q ? 40'({cfg_end_q - 17'd1, 16'h0})
						: 40'({cfg_start_q, 16'h0});
					vage_q[sel_q]  <= age_ctr_q;
					vstep_q[sel_q] <= n_step;
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					m_data_q <= {found_q, 5'(on_count), mix_q};
				end
			end
			default: mix_q <= mix_q;
		endcase
	end

`ifndef ASSERT_OFF
	// the shared divider is never left running once the block is idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !dv_busy_q)
		else $error("divider busy while idle");

	// a sample write stops every voice
	a_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == OP_WRITE)) |=> (on_q == '0))
		else $error("voices alive after sample write");

	// the mix never leaves the saturation range
	a_mix_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (($signed(m_tdata[25:0]) <= 26'sd16777216) &&
			($signed(m_tdata[25:0]) >= -26'sd16777216)))
		else $error("mix out of range");
`endif

endmodule

// ===== verif/tb_sample_voice_pool_player_top.sv =====
`timescale 1ns / 1ps

module tb_sample_voice_pool_player_top;
	import svp_pkg::*;

	// spare operation codes; the block must ignore them
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int         FILL_WORDS = 40;     // words 0..FILL_WORDS-1 hold the test sample
	localparam int         N_ROWS     = 24;
	localparam int         ROWS_BARE  = 7;      // rows run before any register write; the last is a sample write

	typedef struct packed {
		logic [2:0]         op;
		logic [6:0]         key;
		logic signed [16:0] tag;
		logic [15:0]        strength;
		logic signed [15:0] bend;
		logic [6:0]         span;
		logic [15:0]        addr;
		logic signed [11:0] word;
	} note_cmd_t;

	// highest field first, so the layout matches m_tdata
	typedef struct packed {
		logic        found;
		logic [4:0]  active;
		logic [25:0] mix;
	} mix_out_t;

	typedef struct packed {
		note_cmd_t cmd;
		logic      typed;       // expected result is written in the row
		mix_out_t  want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;  // key, voice_tag, strength, bend_amount, bend_span,
	                            // store_address, store_value, zero pad (lowest first)
	logic [2:0]  s_tuser = '0;  // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // mix, active_voices, note_active (lowest first)
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sample_voice_pool_player_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Voice pool model: registers, sample memory, voice table
	// ---------------------------------------------------------------
	longint unsigned     pitch_q30[192];
	logic signed [11:0]  wave_mem[SAMPLE_DEPTH];
	bit                  wave_loaded;
	bit                  v_on[VOICES];
	logic [6:0]          v_key[VOICES];
	int                  v_tag[VOICES];
	longint              v_gain[VOICES];
	bit                  v_back[VOICES];
	longint              v_pos[VOICES];
	longint unsigned     v_step[VOICES];
	int unsigned         v_age[VOICES];
	int unsigned         age_next;
	longint              bend_q16;

	longint cfg_start, cfg_end, cfg_loop, cfg_mode, cfg_rev, cfg_root, cfg_srate, cfg_orate;

	mix_out_t expq[$];
	int       n_err = 0;
	int       n_items = 0;
	int       n_results = 0;
	int       n_ticks = 0;
	int       burst_left = 0;

	function automatic void clear_pool();
		for (int i = 0; i < VOICES; i++) begin
			v_on[i] = 0; v_key[i] = '0; v_tag[i] = 0; v_gain[i] = 0;
			v_back[i] = 0; v_pos[i] = 0; v_step[i] = 0; v_age[i] = 0;
		end
		age_next = 1;
	endfunction

	function automatic void model_reset();
		longint unsigned e;
		e = 64'd1 << 30;
		for (int k = 0; k < 192; k++) begin
			pitch_q30[k] = e;
			e = (e * 64'd1077625190 + (64'd1 << 29)) >> 30;
		end
		foreach (wave_mem[i]) wave_mem[i] = '0;
		wave_loaded = 0;
		clear_pool();
		bend_q16 = 65536;
		cfg_start = 0; cfg_end = 0; cfg_loop = 0; cfg_mode = 0;
		cfg_rev = 0; cfg_root = 960; cfg_srate = 0; cfg_orate = 48000;
	endfunction

	function automatic void model_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_START: cfg_start = val[15:0];
			REG_END:   cfg_end   = val[16:0];
			REG_LOOP:  cfg_loop  = val[16:0];
			REG_MODE:  cfg_mode  = val[1:0];
			REG_REV:   cfg_rev   = val[0];
			REG_ROOT:  cfg_root  = val[10:0];
			REG_SRATE: cfg_srate = val[15:0];
			REG_ORATE: if (val[17:0] != 0) cfg_orate = val[17:0];
			default: ;
		endcase
	endfunction

	function automatic void start_voice(logic [6:0] key, int tag, longint gain);
		int              v;
		int              x;
		int              u;
		longint unsigned num, den, q;
		v = -1;
		if (!wave_loaded || cfg_srate == 0 || cfg_end <= cfg_start || gain == 0)
			return;
		for (int i = 0; i < VOICES; i++)
			if (v < 0 && !v_on[i]) v = i;
		if (v < 0) begin
			// steal the oldest
			v = 0;
			for (int i = 1; i < VOICES; i++)
				if (v_age[i] < v_age[v]) v = i;
		end
		v_on[v] = 1; v_key[v] = key; v_tag[v] = tag; v_gain[v] = gain;
		v_back[v] = cfg_rev != 0;
		v_pos[v] = v_back[v] ? (cfg_end - 1) * 65536 : cfg_start * 65536;
		v_age[v] = age_next;
		age_next++;
		x = int'(key) * 16 - int'(cfg_root);
		u = x + 2304;
		num = longint'(cfg_srate) * pitch_q30[u % 192];
		den = longint'(cfg_orate) << (26 - u / 192);
		q = num / den;
		v_step[v] = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
	endfunction

	function automatic void stop_voices(logic [6:0] key, int tag);
		bit hit;
		for (int i = 0; i < VOICES; i++) begin
			hit = (tag >= 0) ? (v_tag[i] == tag) : (v_key[i] == key);
			if (v_on[i] && hit) begin
				v_on[i] = 0;
				if (tag >= 0) return;
			end
		end
	endfunction

	// one voice's interpolated, gain-scaled sample; wraps/ends and advances the voice
	function automatic longint voice_out(int v);
		longint s, e, h, l, p, span, ph, lim, idx, nxt, frac, s0, s1, adv;
		bit     back;
		s = cfg_start * 65536; e = cfg_end * 65536; h = e - 65536; l = cfg_loop * 65536;
		p = v_pos[v];
		back = v_back[v];
		if (cfg_mode == MODE_ALT && l < h) begin
			span = h - l;
			if (!back && p > h) begin
				ph = (p - h) % (span * 2);
				if (ph <= span) begin
					p = h - ph; back = 1;
				end else p = l + (ph - span);
			end else if (back && p < l) begin
				ph = (l - p) % (span * 2);
				if (ph <= span) begin
					p = l + ph; back = 0;
				end else p = h - (ph - span);
			end
		end else if (!back && p >= e) begin
			if (cfg_mode == MODE_ONESHOT || l >= e) begin
				v_on[v] = 0;
				return 0;
			end
			p = l + (p - e) % (e - l);
		end else if (back && p < ((cfg_mode == MODE_ONESHOT) ? s : l)) begin
			if (cfg_mode == MODE_ONESHOT || l >= e) begin
				v_on[v] = 0;
				return 0;
			end
			ph = (l - p) % (e - l);
			p = (ph == 0) ? l : e - ph;
		end
		idx = p >>> 16;
		lim = cfg_end - 1;
		nxt = idx + 1;
		if (lim >= 0 && nxt > lim) nxt = lim;
		frac = p & 64'hFFFF;
		s0 = wave_mem[idx % SAMPLE_DEPTH];
		s1 = wave_mem[nxt % SAMPLE_DEPTH];
		adv = longint'((v_step[v] * longint'(bend_q16)) >> 16);
		v_pos[v] = back ? p - adv : p + adv;
		v_back[v] = back;
		return (s0 * 65536 + (s1 - s0) * frac) * v_gain[v];
	endfunction

	function automatic mix_out_t model_item(note_cmd_t c);
		mix_out_t r;
		longint   sum, m, x;
		int       u, cnt, sp;
		r = '0;
		sum = 0;
		cnt = 0;
		case (c.op)
			OP_TICK: begin
				for (int i = 0; i < VOICES; i++)
					if (v_on[i]) sum += voice_out(i);
				m = sum >>> 23;
				if (m > (64'sd1 << 24)) m = 64'sd1 << 24;
				if (m < -(64'sd1 << 24)) m = -(64'sd1 << 24);
				r.mix = m[25:0];
			end
			OP_NOTE_ON:  start_voice(c.key, int'(c.tag), longint'(c.strength));
			OP_NOTE_OFF: stop_voices(c.key, int'(c.tag));
			OP_BEND: begin
				sp = c.span;
				if (sp < 1) sp = 1;
				if (sp > 12) sp = 12;
				x = (longint'(c.bend) * sp) >>> 11;
				u = int'(x) + 192;
				bend_q16 = pitch_q30[u % 192] >> (15 - u / 192);
			end
			OP_WRITE: begin
				wave_mem[c.addr] = c.word;
				wave_loaded = 1;
				clear_pool();
			end
			OP_QUERY:
				for (int i = 0; i < VOICES; i++)
					if (v_on[i] && v_key[i] == c.key && (c.tag < 0 || v_tag[i] == int'(c.tag)))
						r.found = 1;
			default: ;
		endcase
		for (int i = 0; i < VOICES; i++)
			if (v_on[i]) cnt++;
		r.active = cnt[4:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// register write: setup cycle then access cycle
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		model_reg(idx, val);
	endtask

	// present one item; valid stays high into the next call unless a gap is due
	task automatic send_cmd(note_cmd_t c, bit typed, mix_out_t want);
		mix_out_t r;
		s_tdata  <= {5'b0, c.word, c.addr, c.span, c.bend, c.strength, c.tag, c.key};
		s_tuser  <= c.op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = model_item(c);
		expq.push_back(typed ? want : r);
		n_items++;
		if (c.op == OP_TICK) n_ticks++;
		if (burst_left > 0) burst_left--;
		else begin
			// bursts of random length; occasional long gapless runs
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
			                                          : $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	endtask

	task automatic send_plain(note_cmd_t c);
		send_cmd(c, 1'b0, '0);
	endtask

	// stop sending, let every outstanding result drain, then a short pause
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expq.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic load_wave();
		note_cmd_t c;
		for (int a = 0; a < FILL_WORDS; a++) begin
			c = '0;
			c.op = OP_WRITE;
			c.addr = 16'(a);
			c.word = (a == 0) ? 12'sd2047 : (a == 1) ? -12'sd2048 : 12'($urandom);
			send_plain(c);
		end
	endtask

	// one register setting; a sample write afterwards flushes any playing voice
	task automatic set_phase(int st, int en, int lp, logic [1:0] md, bit rv,
	                         int rt, int sr, int orate);
		note_cmd_t c;
		drain();
		write_reg(REG_START, st);
		write_reg(REG_END, en);
		write_reg(REG_LOOP, lp);
		write_reg(REG_MODE, 32'(md));
		write_reg(REG_REV, 32'(rv));
		write_reg(REG_ROOT, rt);
		write_reg(REG_SRATE, sr);
		write_reg(REG_ORATE, orate);
		c = note_cmd_t'(94'({$urandom, $urandom, $urandom}));
		c.op = OP_WRITE;
		c.addr = (en > FILL_WORDS) ? 16'hFFFF : 16'($urandom_range(0, FILL_WORDS - 1));
		send_plain(c);
	endtask

	// mostly note traffic on a handful of keys and tags, so note-off and
	// query find their targets; ticks dominate; rare writes restart the pool
	task automatic random_traffic(int n);
		note_cmd_t c;
		int        r;
		for (int i = 0; i < n; i++) begin
			c = note_cmd_t'(94'({$urandom, $urandom, $urandom}));
			r = $urandom_range(0, 99);
			if (r < 42) c.op = OP_TICK;
			else if (r < 64) c.op = OP_NOTE_ON;
			else if (r < 76) c.op = OP_NOTE_OFF;
			else if (r < 84) c.op = OP_BEND;
			else if (r < 96) c.op = OP_QUERY;
			else if (r < 98) c.op = OP_WRITE;
			else c.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
			if ($urandom_range(0, 3) != 0) c.key = 7'(56 + $urandom_range(0, 7));
			r = $urandom_range(0, 5);
			if (r < 2) c.tag = -17'sd1;
			else if (r < 5) c.tag = 17'($urandom_range(0, 7));
			else c.tag = 17'($urandom_range(0, 65535));
			if ($urandom_range(0, 9) == 0) c.strength = '0;
			if ($urandom_range(0, 1) == 0) c.span = 7'($urandom_range(0, 14));
			send_plain(c);
		end
	endtask

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		mix_out_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			n_results++;
			if (expq.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, m_tdata);
				n_err++;
			end else begin
				want = expq.pop_front();
				if (got.mix !== want.mix) begin
					$display("%0t: mix expected %h actual %h", $time, want.mix, got.mix);
					n_err++;
				end
				if (got.active !== want.active) begin
					$display("%0t: active_voices expected %0d actual %0d",
					         $time, want.active, got.active);
					n_err++;
				end
				if (got.found !== want.found) begin
					$display("%0t: note_active expected %b actual %b",
					         $time, want.found, got.found);
					n_err++;
				end
			end
		end
	end

	// receiver stall pattern: busy windows of sparse stalls, quiet windows of none
	int unsigned rx_cnt = 0;
	always @(posedge clk) begin
		rx_cnt <= rx_cnt + 1;
		if ((rx_cnt % 53) < 20) m_tready <= ((rx_cnt % 5) != 0) && ((rx_cnt % 7) != 3);
		else m_tready <= 1'b1;
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic dir_row_t row(logic [2:0] op, logic [6:0] key, int tag, int strength,
	                                 int bend, int span, int addr, int word, bit typed);
		dir_row_t d;
		d = '0;
		d.cmd.op = op; d.cmd.key = key; d.cmd.tag = 17'(tag); d.cmd.strength = 16'(strength);
		d.cmd.bend = 16'(bend); d.cmd.span = 7'(span); d.cmd.addr = 16'(addr);
		d.cmd.word = 12'(word);
		d.typed = typed;    // typed rows all expect an empty pool and a zero result
		return d;
	endfunction

	dir_row_t rows[N_ROWS];

	initial begin
		model_reset();
		// before any sample exists: everything answers zero, nothing starts; the last row writes one
		rows[0]  = row(OP_NOTE_ON, 60, 1, 65535, 0, 0, 0, 0, 1);
		rows[1]  = row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 1);
		rows[2]  = row(OP_QUERY, 60, -1, 0, 0, 0, 0, 0, 1);
		rows[3]  = row(OP_SPARE_A, 127, 65535, 65535, -1, 127, 65535, -1, 1);
		rows[4]  = row(OP_SPARE_B, 0, -1, 0, 0, 0, 0, 0, 1);
		rows[5]  = row(OP_NOTE_OFF, 60, -1, 0, 0, 0, 0, 0, 1);
		rows[6]  = row(OP_WRITE, 0, 0, 0, 0, 0, 65535, -2048, 1);
		// with a sample: key extremes, zero velocity, bend extremes, both kinds of release
		rows[7]  = row(OP_NOTE_ON, 0, 0, 65535, 0, 0, 0, 0, 0);
		rows[8]  = row(OP_NOTE_ON, 127, 65535, 1, 0, 0, 0, 0, 0);
		rows[9]  = row(OP_NOTE_ON, 64, 5, 0, 0, 0, 0, 0, 0);
		rows[10] = row(OP_NOTE_ON, 60, 7, 32768, 0, 0, 0, 0, 0);
		rows[11] = row(OP_QUERY, 60, -1, 0, 0, 0, 0, 0, 0);
		rows[12] = row(OP_QUERY, 60, 6, 0, 0, 0, 0, 0, 0);
		rows[13] = row(OP_QUERY, 127, 65535, 0, 0, 0, 0, 0, 0);
		rows[14] = row(OP_BEND, 0, 0, 0, 32767, 127, 0, 0, 0);
		rows[15] = row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
		rows[16] = row(OP_BEND, 0, 0, 0, -32768, 0, 0, 0, 0);
		rows[17] = row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
		rows[18] = row(OP_BEND, 0, 0, 0, 0, 12, 0, 0, 0);
		rows[19] = row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
		rows[20] = row(OP_NOTE_OFF, 0, 65535, 0, 0, 0, 0, 0, 0);
		rows[21] = row(OP_NOTE_OFF, 60, -1, 0, 0, 0, 0, 0, 0);
		rows[22] = row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
		rows[23] = row(OP_QUERY, 0, -1, 0, 0, 0, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ROWS_BARE; i++) send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);

		// forward loop, typical rates
		set_phase(0, 32, 8, 2'd1, 1'b0, 960, 44100, 48000);
		load_wave();
		for (int i = ROWS_BARE; i < N_ROWS; i++)
			send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);
		random_traffic(90);

		// alternating loop, reversed start, saturated steps; a zero output rate is dropped
		set_phase(4, 36, 20, MODE_ALT, 1'b1, 0, 65535, 1);
		drain();
		write_reg(REG_ORATE, 0);
		random_traffic(90);

		// one-shot with an empty loop region, slowest rates
		set_phase(10, 40, 40, MODE_ONESHOT, 1'b0, 2047, 8000, 262143);
		random_traffic(80);

		// undefined mode code behaves as forward loop; backward wrap through zero
		set_phase(2, 30, 0, 2'd3, 1'b1, 1100, 22050, 44100);
		random_traffic(90);

		// top of memory: single word sample
		set_phase(65535, 65536, 65536, MODE_ONESHOT, 1'b1, 960, 48000, 48000);
		random_traffic(60);

		// empty sample range: every note-on refused
		set_phase(0, 0, 0, 2'd1, 1'b0, 960, 48000, 48000);
		random_traffic(100);

		drain();
		repeat (50) @(posedge clk);

		$display("Run covered %0d items (%0d ticks) over six register settings; %0d results.",
		         n_items, n_ticks, n_results);
		if (n_err == 0 && expq.size() == 0)
			$display("sample_voice_pool_player_top verification clean");
		else
			$display("sample_voice_pool_player_top verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#10000000;
		$display("timeout with %0d results outstanding", expq.size());
		$display("sample_voice_pool_player_top verification failed");
		$finish;
	end

endmodule
